FILE: design/jts_pkg.sv
`timescale 1ns / 1ps

package jts_pkg;

    // Width of the internal byte counter; spans leave the block at a fixed width.
    localparam int POS_BITS = 24;
    localparam int SPAN_W   = 24;
    localparam int WIDE_W   = (POS_BITS > SPAN_W) ? POS_BITS : SPAN_W;

    // Input queue and result queue sizes.
    localparam int IQ_AW    = 1;
    localparam int IQ_DEPTH = 2 ** IQ_AW;
    localparam int OQ_AW    = 2;
    localparam int OQ_DEPTH = 2 ** OQ_AW;

    // Byte classes found by the front end.
    localparam logic [3:0] C_LBRACE = 4'd0;
    localparam logic [3:0] C_RBRACE = 4'd1;
    localparam logic [3:0] C_LBRACK = 4'd2;
    localparam logic [3:0] C_RBRACK = 4'd3;
    localparam logic [3:0] C_COLON  = 4'd4;
    localparam logic [3:0] C_COMMA  = 4'd5;
    localparam logic [3:0] C_T      = 4'd6;
    localparam logic [3:0] C_F      = 4'd7;
    localparam logic [3:0] C_N      = 4'd8;
    localparam logic [3:0] C_QUOTE  = 4'd9;
    localparam logic [3:0] C_WS     = 4'd10;
    localparam logic [3:0] C_MINUS  = 4'd11;
    localparam logic [3:0] C_DIGIT  = 4'd12;
    localparam logic [3:0] C_DOT    = 4'd13;
    localparam logic [3:0] C_BSLASH = 4'd14;
    localparam logic [3:0] C_OTHER  = 4'd15;

    // Token kinds.
    localparam logic [3:0] K_LBRACE = 4'd0;
    localparam logic [3:0] K_RBRACE = 4'd1;
    localparam logic [3:0] K_LBRACK = 4'd2;
    localparam logic [3:0] K_RBRACK = 4'd3;
    localparam logic [3:0] K_COLON  = 4'd4;
    localparam logic [3:0] K_COMMA  = 4'd5;
    localparam logic [3:0] K_TRUE   = 4'd6;
    localparam logic [3:0] K_FALSE  = 4'd7;
    localparam logic [3:0] K_NULL   = 4'd8;
    localparam logic [3:0] K_NUMBER = 4'd9;
    localparam logic [3:0] K_STRING = 4'd10;
    localparam logic [3:0] K_END    = 4'd11;
    localparam logic [3:0] K_ERROR  = 4'd12;

    // Error codes.
    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_LITERAL = 2'd1;
    localparam logic [1:0] E_NOQUOTE = 2'd2;
    localparam logic [1:0] E_BADBYTE = 2'd3;

    // One classified input beat.
    typedef struct packed {
        logic       src_end;
        logic [7:0] text;
        logic [3:0] cls;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [3:0]        kind;
        logic [1:0]        err;
        logic [SPAN_W-1:0] start;
        logic [SPAN_W-1:0] len;
        logic              last;
    } t_res;

    // Bring a position value to span width, dropping or adding upper bits.
    function automatic logic [SPAN_W-1:0] to_span(input logic [POS_BITS-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[SPAN_W-1:0];
    endfunction

endpackage

FILE: design/jts_front.sv
`timescale 1ns / 1ps

module jts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    i_text_byte,
    input  logic          i_source_end,
    output logic          o_valid,
    output jts_pkg::t_item o_item,
    input  logic          i_take
);
    import jts_pkg::*;

    t_item            r_q [IQ_DEPTH];
    logic [IQ_AW-1:0] r_wp, r_rp;
    logic [IQ_AW:0]   r_cnt;
    logic [IQ_AW:0]   n_cnt;
    logic [3:0]       cls;
    logic             do_push, do_pop;

    // Classify the incoming byte so the scanner only sees a small code.
    always_comb begin
        unique case (i_text_byte)
            8'h7B: cls = C_LBRACE;
            8'h7D: cls = C_RBRACE;
            8'h5B: cls = C_LBRACK;
            8'h5D: cls = C_RBRACK;
            8'h3A: cls = C_COLON;
            8'h2C: cls = C_COMMA;
            8'h74: cls = C_T;
            8'h66: cls = C_F;
            8'h6E: cls = C_N;
            8'h22: cls = C_QUOTE;
            8'h20, 8'h0D, 8'h0A, 8'h09: cls = C_WS;
            8'h2D: cls = C_MINUS;
            8'h2E: cls = C_DOT;
            8'h5C: cls = C_BSLASH;
            default: begin
                if (i_text_byte >= 8'h30 && i_text_byte <= 8'h39) begin
                    cls = C_DIGIT;
                end else begin
                    cls = C_OTHER;
                end
            end
        endcase
    end

    assign full    = (r_cnt == (IQ_AW+1)'(IQ_DEPTH));
    assign do_push = push && !full;
    assign o_valid = (r_cnt != '0);
    assign do_pop  = i_take && o_valid;
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= '{src_end: i_source_end, text: i_text_byte, cls: cls};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    // The fill count never exceeds the queue depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (IQ_AW+1)'(IQ_DEPTH))
        else $error("input queue count out of range");

    // A beat taken by the scanner leaves the count one lower unless a push came in.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("input queue count did not drop on pop");

    // The pointers are equal whenever the count is zero.
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("input queue pointers disagree with empty count");

endmodule

FILE: design/jts_engine.sv
`timescale 1ns / 1ps

module jts_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  jts_pkg::t_item i_item,
    input  logic           i_room,
    output logic           o_take,
    output logic [1:0]     o_n,
    output jts_pkg::t_res  o_r0,
    output jts_pkg::t_res  o_r1
);
    import jts_pkg::*;

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_TRUE  = 4'd1;
    localparam logic [3:0] M_FALSE = 4'd2;
    localparam logic [3:0] M_NULL  = 4'd3;
    localparam logic [3:0] M_INT   = 4'd4;
    localparam logic [3:0] M_DOT   = 4'd5;
    localparam logic [3:0] M_FRAC  = 4'd6;
    localparam logic [3:0] M_STR   = 4'd7;
    localparam logic [3:0] M_ESC   = 4'd8;
    localparam logic [3:0] M_HEX   = 4'd9;
    localparam logic [3:0] M_DONE  = 4'd10;
    localparam logic [3:0] M_HALT  = 4'd11;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [3:0]          r_mode, n_mode;
    logic [2:0]          r_prog, n_prog;
    logic [2:0]          r_hex, n_hex;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_tbeg, n_tbeg;

    logic [POS_BITS-1:0] pinc, pdec, len_p, len_pinc, len_dot;
    logic [7:0]          c;
    logic [3:0]          cls;
    logic                eod;
    logic [2:0]          lit_n;
    logic [3:0]          lit_kind;
    logic                lit_ok;
    logic                va, vb, vs, restart;
    t_res                ra, rb, rs;

    function automatic logic [POS_BITS-1:0] span_len(input logic [POS_BITS-1:0] a,
                                                     input logic [POS_BITS-1:0] b);
        return (b >= a) ? b - a : '0;
    endfunction

    function automatic t_res mk_res(input logic [3:0] kind, input logic [1:0] err,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [POS_BITS-1:0] len);
        t_res r;
        r.kind  = kind;
        r.err   = err;
        r.start = to_span(start);
        r.len   = to_span(len);
        r.last  = 1'b0;
        return r;
    endfunction

    // Expected letter of a literal after its first letter.
    function automatic logic [7:0] lit_char(input logic [3:0] mode, input logic [2:0] prog);
        logic [7:0] ch;
        ch = 8'h00;
        if (mode == M_TRUE) begin
            ch = (prog == 3'd0) ? 8'h72 : (prog == 3'd1) ? 8'h75 : 8'h65;
        end else if (mode == M_FALSE) begin
            ch = (prog == 3'd0) ? 8'h61 : (prog == 3'd1) ? 8'h6C :
                 (prog == 3'd2) ? 8'h73 : 8'h65;
        end else begin
            ch = (prog == 3'd0) ? 8'h75 : 8'h6C;
        end
        return ch;
    endfunction

    assign c        = i_item.text;
    assign cls      = i_item.cls;
    assign eod      = i_item.src_end;
    assign o_take   = i_valid && i_room;
    assign pinc     = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign pdec     = (r_pos != '0) ? r_pos - 1'b1 : '0;
    assign len_p    = span_len(r_tbeg, r_pos);
    assign len_pinc = span_len(r_tbeg, pinc);
    assign len_dot  = (len_p != '0) ? len_p - 1'b1 : '0;
    assign lit_n    = (r_mode == M_FALSE) ? 3'd4 : 3'd3;
    assign lit_kind = (r_mode == M_TRUE) ? K_TRUE : (r_mode == M_FALSE) ? K_FALSE : K_NULL;
    assign lit_ok   = (r_prog < lit_n) && (c == lit_char(r_mode, r_prog));

    // Main step: the current mode decides what the beat does; a byte seen in idle mode
    // or one that ends a number is handed on to the token start logic below.
    always_comb begin
        n_mode  = r_mode;
        n_prog  = r_prog;
        n_hex   = r_hex;
        n_pos   = r_pos;
        n_tbeg  = r_tbeg;
        va      = 1'b0;
        vb      = 1'b0;
        vs      = 1'b0;
        restart = 1'b0;
        ra      = mk_res(K_END, E_NONE, r_pos, '0);
        rb      = ra;
        rs      = ra;
        if (o_take && r_mode != M_HALT) begin
            if (eod) begin
                unique case (r_mode)
                    M_IDLE, M_DONE: begin
                        va     = 1'b1;
                        n_mode = M_DONE;
                    end
                    M_TRUE, M_FALSE, M_NULL: begin
                        va     = 1'b1;
                        ra     = mk_res(K_ERROR, E_LITERAL, r_tbeg, len_p);
                        n_mode = M_HALT;
                    end
                    M_INT, M_FRAC: begin
                        va     = 1'b1;
                        vb     = 1'b1;
                        ra     = mk_res(K_NUMBER, E_NONE, r_tbeg, len_p);
                        rb     = mk_res(K_END, E_NONE, r_pos, '0);
                        n_mode = M_DONE;
                    end
                    M_DOT: begin
                        va     = 1'b1;
                        vb     = 1'b1;
                        ra     = mk_res(K_NUMBER, E_NONE, r_tbeg, len_dot);
                        rb     = mk_res(K_ERROR, E_BADBYTE, pdec, POS_BITS'(1));
                        n_mode = M_HALT;
                    end
                    M_STR, M_ESC, M_HEX: begin
                        va     = 1'b1;
                        ra     = mk_res(K_ERROR, E_NOQUOTE, r_tbeg, len_p);
                        n_hex  = '0;
                        n_mode = M_HALT;
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end else if (r_mode != M_DONE) begin
                n_pos = pinc;
                unique case (r_mode)
                    M_IDLE: begin
                        restart = 1'b1;
                    end
                    M_TRUE, M_FALSE, M_NULL: begin
                        if (lit_ok) begin
                            n_prog = r_prog + 1'b1;
                            if (r_prog + 1'b1 == lit_n) begin
                                va     = 1'b1;
                                ra     = mk_res(lit_kind, E_NONE, r_tbeg, len_pinc);
                                n_mode = M_IDLE;
                                n_prog = '0;
                            end
                        end else begin
                            va     = 1'b1;
                            ra     = mk_res(K_ERROR, E_LITERAL, r_tbeg, len_pinc);
                            n_mode = M_HALT;
                        end
                    end
                    M_INT, M_FRAC: begin
                        if (cls == C_DIGIT) begin
                            n_mode = r_mode;
                        end else if (r_mode == M_INT && cls == C_DOT) begin
                            n_mode = M_DOT;
                        end else begin
                            va      = 1'b1;
                            ra      = mk_res(K_NUMBER, E_NONE, r_tbeg, len_p);
                            n_mode  = M_IDLE;
                            restart = 1'b1;
                        end
                    end
                    M_DOT: begin
                        if (cls == C_DIGIT) begin
                            n_mode = M_FRAC;
                        end else begin
                            va     = 1'b1;
                            vb     = 1'b1;
                            ra     = mk_res(K_NUMBER, E_NONE, r_tbeg, len_dot);
                            rb     = mk_res(K_ERROR, E_BADBYTE, pdec, POS_BITS'(1));
                            n_mode = M_HALT;
                        end
                    end
                    M_STR: begin
                        if (cls == C_QUOTE) begin
                            va     = 1'b1;
                            ra     = mk_res(K_STRING, E_NONE, r_tbeg, len_p);
                            n_mode = M_IDLE;
                        end else if (cls == C_BSLASH) begin
                            n_mode = M_ESC;
                        end
                    end
                    M_ESC: begin
                        if (c == 8'h75) begin
                            n_mode = M_HEX;
                            n_hex  = 3'd4;
                        end else begin
                            n_mode = M_STR;
                        end
                    end
                    M_HEX: begin
                        n_hex = (r_hex != '0) ? r_hex - 1'b1 : r_hex;
                        if (n_hex == '0) begin
                            n_mode = M_STR;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end

            // Token start: a byte between tokens opens a token; whitespace is skipped.
            if (restart) begin
                unique case (cls)
                    C_LBRACE: begin
                        vs = 1'b1;
                        rs = mk_res(K_LBRACE, E_NONE, r_pos, POS_BITS'(1));
                    end
                    C_RBRACE: begin
                        vs = 1'b1;
                        rs = mk_res(K_RBRACE, E_NONE, r_pos, POS_BITS'(1));
                    end
                    C_LBRACK: begin
                        vs = 1'b1;
                        rs = mk_res(K_LBRACK, E_NONE, r_pos, POS_BITS'(1));
                    end
                    C_RBRACK: begin
                        vs = 1'b1;
                        rs = mk_res(K_RBRACK, E_NONE, r_pos, POS_BITS'(1));
                    end
                    C_COLON: begin
                        vs = 1'b1;
                        rs = mk_res(K_COLON, E_NONE, r_pos, POS_BITS'(1));
                    end
                    C_COMMA: begin
                        vs = 1'b1;
                        rs = mk_res(K_COMMA, E_NONE, r_pos, POS_BITS'(1));
                    end
                    C_T, C_F, C_N: begin
                        n_mode = (cls == C_T) ? M_TRUE : (cls == C_F) ? M_FALSE : M_NULL;
                        n_prog = '0;
                        n_tbeg = r_pos;
                    end
                    C_QUOTE: begin
                        n_mode = M_STR;
                        n_tbeg = pinc;
                    end
                    C_WS: begin
                        n_mode = M_IDLE;
                    end
                    C_MINUS, C_DIGIT: begin
                        n_mode = M_INT;
                        n_tbeg = r_pos;
                    end
                    default: begin
                        vs     = 1'b1;
                        rs     = mk_res(K_ERROR, E_BADBYTE, r_pos, POS_BITS'(1));
                        n_mode = M_HALT;
                    end
                endcase
            end
        end
    end

    // Pack the results of this beat in order and mark the final one.
    always_comb begin
        o_r0 = va ? ra : rs;
        o_r1 = vb ? rb : rs;
        o_n  = 2'(va) + 2'(vb) + 2'(vs);
        o_r0.last = (o_n == 2'd1);
        o_r1.last = 1'b1;
    end

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_prog <= '0;
            r_hex  <= '0;
            r_pos  <= '0;
            r_tbeg <= '0;
        end else begin
            r_mode <= n_mode;
            r_prog <= n_prog;
            r_hex  <= n_hex;
            r_pos  <= n_pos;
            r_tbeg <= n_tbeg;
        end
    end

    // Once halted, the scanner stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |=> (r_mode == M_HALT))
        else $error("scanner left the halted mode");

    // An error result always halts the scanner on the next cycle.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_n != 2'd0 && ((o_n == 2'd1 && o_r0.kind == K_ERROR) ||
                         (o_n == 2'd2 && o_r1.kind == K_ERROR)))
        |=> (r_mode == M_HALT))
        else $error("error token without halt");

    // The byte position never moves backward.
    a_pos_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_pos >= $past(r_pos)))
        else $error("byte position went backward");

    // Nothing is produced in a cycle without a taken beat.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |-> (o_n == 2'd0))
        else $error("result produced without an input beat");

endmodule

FILE: design/jts_res_q.sv
`timescale 1ns / 1ps

module jts_res_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_n,
    input  jts_pkg::t_res i_r0,
    input  jts_pkg::t_res i_r1,
    output logic          o_room,
    output logic          empty,
    input  logic          pop,
    output jts_pkg::t_res o_head
);
    import jts_pkg::*;

    t_res             r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic [OQ_AW-1:0] wp1;
    logic             do_pop;

    assign wp1    = r_wp + 1'b1;
    assign empty  = (r_cnt == '0);
    assign do_pop = pop && !empty;
    assign o_room = (r_cnt <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign o_head = r_q[r_rp];

    // Up to two results are written per cycle at consecutive slots.
    always_ff @(posedge i_clk) begin
        if (i_n != 2'd0) begin
            r_q[r_wp] <= i_r0;
        end
        if (i_n == 2'd2) begin
            r_q[wp1] <= i_r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + OQ_AW'(i_n);
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OQ_AW+1)'(i_n) - (OQ_AW+1)'(do_pop);
        end
    end

    // Results only arrive when two free slots were announced.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_n != 2'd0) |-> o_room)
        else $error("result queue written without room");

    // The fill count never exceeds the queue depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue count out of range");

    // A pair written together ends with its final result marked.
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_n == 2'd2) |-> (i_r1.last && !i_r0.last))
        else $error("result pair marked wrongly");

endmodule

FILE: design/json_token_scanner_core.sv
`timescale 1ns / 1ps

// Streaming JSON lexer that takes one source byte (or an end-of-source marker) per
// beat and returns tokens: punctuation, true/false/null, numbers and strings as
// spans of the source, plus an end token or a single error token, after which the
// block ignores all input until reset. It accepts one byte per clock cycle unless
// full is high; the scanner step is combinational, so the input rate is bounded
// only by the 4-entry result queue draining at one result per cycle, since a byte
// ending a number can produce two results. A pushed byte waits in a 2-entry input
// queue, is scanned at its head when the result queue has room, and its results
// are registered there. No clearing pass follows reset; positions saturate at 2^24-1.
module json_token_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_source_end,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_token_kind,
    output logic [1:0]  o_error_code,
    output logic [23:0] o_span_start,
    output logic [23:0] o_span_length,
    output logic        o_last_of_run
);
    import jts_pkg::*;

    logic       item_valid, take, room;
    t_item      item;
    logic [1:0] res_n;
    t_res       res0, res1, head;

    // Front end: accept and classify source bytes.
    jts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_text_byte  (i_text_byte),
        .i_source_end (i_source_end),
        .o_valid      (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    // Scanner state machine.
    jts_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .i_room  (room),
        .o_take  (take),
        .o_n     (res_n),
        .o_r0    (res0),
        .o_r1    (res1)
    );

    // Result queue toward the consumer.
    jts_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_n     (res_n),
        .i_r0    (res0),
        .i_r1    (res1),
        .o_room  (room),
        .empty   (empty),
        .pop     (pop),
        .o_head  (head)
    );

    assign o_token_kind  = head.kind;
    assign o_error_code  = head.err;
    assign o_span_start  = head.start;
    assign o_span_length = head.len;
    assign o_last_of_run = head.last;

endmodule
